@@ rtl/core/lpf_pkg.sv @@
// Package for the layer-4 port filter: shared types, codes and protocol constants.
// No dependencies; all files but the two interfaces refer to it by scoped names.
package lpf_pkg;

  // Item codes on the input channel.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_RULE  = 1'b1;

  // Reason codes on the result channel.
  localparam logic [2:0] REASON_RUNT      = 3'd0;
  localparam logic [2:0] REASON_TRUNCATED = 3'd1;
  localparam logic [2:0] REASON_NOT_IPV4  = 3'd2;
  localparam logic [2:0] REASON_NOT_L4    = 3'd3;
  localparam logic [2:0] REASON_NO_RULE   = 3'd4;
  localparam logic [2:0] REASON_RULE_PASS = 3'd5;
  localparam logic [2:0] REASON_RULE_DROP = 3'd6;

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] TYPE_VLAN   = 16'h8100;
  localparam logic [15:0] TYPE_QINQ   = 16'h88A8;
  localparam logic [15:0] TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  ACTION_DROP = 8'd1;

  localparam logic [4:0] ETH_HDR_LEN  = 5'd14;
  localparam logic [3:0] IP_MIN_WORDS = 4'd5;
  localparam logic [8:0] UDP_HDR_LEN  = 9'd8;
  localparam logic [8:0] TCP_HDR_LEN  = 9'd20;
  localparam logic [4:0] TAG_LEN      = 5'd4;

  // Command queue between parser and matcher.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  // Entries per group in the first level of the priority tree.
  localparam int GROUP_SIZE  = 16;

  typedef enum logic [2:0] {
    PH_ETH,
    PH_IP,
    PH_L4,
    PH_NOT_IP,
    PH_NOT_L4,
    PH_BAD
  } phase_t;

  // One queued command: either a rule write or a classified frame.
  typedef struct packed {
    logic        is_rule;
    logic        lookup;
    logic [2:0]  reason;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [6:0]  index;
    logic        drop;
    logic        valid;
  } cmd_t;

endpackage

@@ rtl/core/lpf_in_if.sv @@
// Input channel of the port filter: valid/ready handshake with frame byte and rule payload.
// Depends on nothing.
interface lpf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [6:0]  rule_index;
  logic [7:0]  rule_protocol;
  logic [15:0] rule_port;
  logic [7:0]  rule_action;
  logic        rule_valid;

  modport source (output valid, opcode, data_byte, last_byte, rule_index, rule_protocol,
                  rule_port, rule_action, rule_valid, input ready);
  modport sink (input valid, opcode, data_byte, last_byte, rule_index, rule_protocol,
                rule_port, rule_action, rule_valid, output ready);
endinterface

@@ rtl/core/lpf_out_if.sv @@
// Result channel of the port filter: valid/ready handshake with verdict and counters.
// Depends on nothing.
interface lpf_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [2:0]  reason;
  logic [6:0]  matched_index;
  logic [63:0] drop_total;
  logic [63:0] pass_total;

  modport source (output valid, verdict, reason, matched_index, drop_total, pass_total,
                  input ready);
  modport sink (input valid, verdict, reason, matched_index, drop_total, pass_total,
                output ready);
endinterface

@@ rtl/core/l4_port_firewall_filter.sv @@
// Layer-4 port filter: takes one frame byte or one rule write per cycle and gives one
// verdict per frame. The parser accepts a transaction every cycle while its four-entry
// command queue has room; the matcher drains that queue at one command per cycle while
// the result side is not stalling, through a four-stage pipeline (command register, rule
// compare, group priority, final priority with counters). A rule write takes effect when
// it leaves the queue, in order with the frames around it. Rule valid bits clear at reset,
// so no clearing pass is needed.
module l4_port_firewall_filter #(
  parameter int RULES    = 128,
  parameter int MAX_TAGS = 2
) (
  input  logic     clk,
  input  logic     rst,
  lpf_in_if.sink   item,
  lpf_out_if.source result
);

  logic          push, full, not_empty, pop, take;
  lpf_pkg::cmd_t push_cmd, head;

  assign item.ready = !full;
  assign take       = item.valid && item.ready;

  lpf_parser #(.MAX_TAGS(MAX_TAGS)) u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .opcode       (item.opcode),
    .data_byte    (item.data_byte),
    .last_byte    (item.last_byte),
    .rule_index   (item.rule_index),
    .rule_protocol(item.rule_protocol),
    .rule_port    (item.rule_port),
    .rule_action  (item.rule_action),
    .rule_valid   (item.rule_valid),
    .push         (push),
    .cmd          (push_cmd)
  );

  lpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .not_empty(not_empty),
    .head     (head)
  );

  lpf_matcher #(.RULES(RULES)) u_matcher (
    .clk          (clk),
    .rst          (rst),
    .cmd_ready    (not_empty),
    .head         (head),
    .pop          (pop),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .verdict      (result.verdict),
    .reason       (result.reason),
    .matched_index(result.matched_index),
    .drop_total   (result.drop_total),
    .pass_total   (result.pass_total)
  );

endmodule

@@ rtl/core/lpf_parser.sv @@
// Front end of the port filter: walks each frame byte by byte and classifies it.
// Depends on lpf_pkg; emits one lpf_pkg::cmd_t per last byte or rule write.
module lpf_parser #(
  parameter int MAX_TAGS = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          opcode,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic [6:0]    rule_index,
  input  logic [7:0]    rule_protocol,
  input  logic [15:0]   rule_port,
  input  logic [7:0]    rule_action,
  input  logic          rule_valid,
  output logic          push,
  output lpf_pkg::cmd_t cmd
);

  localparam int TCW = (MAX_TAGS > 0) ? $clog2(MAX_TAGS + 1) : 1;

  logic [7:0]      byte_offset, byte_offset_next;
  logic [15:0]     ether_type, ether_type_next;
  logic [TCW-1:0]  tag_count, tag_count_next;
  logic [4:0]      network_start, network_start_next;
  logic [3:0]      header_words, header_words_next;
  logic [7:0]      ip_protocol, ip_protocol_next;
  logic [15:0]     dest_port, dest_port_next;
  lpf_pkg::phase_t parse_phase, parse_phase_next;

  logic [7:0] rel_ip, rel_l4;
  logic [8:0] length, need_end;
  logic       frame_byte;

  assign frame_byte = take && (opcode == lpf_pkg::OP_FRAME);
  assign length     = {1'b0, byte_offset} + 9'd1;
  assign rel_ip     = byte_offset - {3'b000, network_start};
  assign rel_l4     = byte_offset - {3'b000, network_start} - {2'b00, header_words, 2'b00};

  always_comb begin
    byte_offset_next   = (byte_offset == 8'hFF) ? byte_offset : byte_offset + 8'd1;
    ether_type_next    = ether_type;
    tag_count_next     = tag_count;
    network_start_next = network_start;
    header_words_next  = header_words;
    ip_protocol_next   = ip_protocol;
    dest_port_next     = dest_port;
    parse_phase_next   = parse_phase;
    case (parse_phase)
      lpf_pkg::PH_ETH: begin
        if (byte_offset == {3'b000, network_start} - 8'd2) begin
          ether_type_next = {data_byte, ether_type[7:0]};
        end else if (byte_offset == {3'b000, network_start} - 8'd1) begin
          ether_type_next = {ether_type[15:8], data_byte};
          if ((ether_type_next == lpf_pkg::TYPE_VLAN || ether_type_next == lpf_pkg::TYPE_QINQ)
              && (32'(tag_count) < MAX_TAGS)) begin
            tag_count_next     = tag_count + TCW'(1);
            network_start_next = network_start + lpf_pkg::TAG_LEN;
          end else if (ether_type_next == lpf_pkg::TYPE_IPV4) begin
            parse_phase_next = lpf_pkg::PH_IP;
          end else begin
            parse_phase_next = lpf_pkg::PH_NOT_IP;
          end
        end
      end
      lpf_pkg::PH_IP: begin
        if (rel_ip == 8'd0) begin
          header_words_next = data_byte[3:0];
        end else if (rel_ip == 8'd9) begin
          ip_protocol_next = data_byte;
        end
        if (rel_ip == 8'd19 && header_words_next < lpf_pkg::IP_MIN_WORDS) begin
          parse_phase_next = lpf_pkg::PH_BAD;
        end else if (rel_ip >= 8'd19 &&
                     rel_ip == {2'b00, header_words_next, 2'b00} - 8'd1) begin
          if (ip_protocol_next == lpf_pkg::PROTO_TCP || ip_protocol_next == lpf_pkg::PROTO_UDP)
          begin
            parse_phase_next = lpf_pkg::PH_L4;
          end else begin
            parse_phase_next = lpf_pkg::PH_NOT_L4;
          end
        end
      end
      lpf_pkg::PH_L4: begin
        if (rel_l4 == 8'd2) begin
          dest_port_next = {data_byte, dest_port[7:0]};
        end else if (rel_l4 == 8'd3) begin
          dest_port_next = {dest_port[15:8], data_byte};
        end
      end
      default: begin
      end
    endcase
  end

  assign need_end = {4'b0000, network_start_next} + {3'b000, header_words_next, 2'b00} +
                    ((ip_protocol_next == lpf_pkg::PROTO_UDP) ? lpf_pkg::UDP_HDR_LEN
                                                              : lpf_pkg::TCP_HDR_LEN);

  always_comb begin
    cmd = '0;
    if (opcode == lpf_pkg::OP_RULE) begin
      cmd.is_rule = 1'b1;
      cmd.index   = rule_index;
      cmd.proto   = rule_protocol;
      cmd.port    = rule_port;
      cmd.drop    = (rule_action == lpf_pkg::ACTION_DROP);
      cmd.valid   = rule_valid;
    end else begin
      cmd.proto  = ip_protocol_next;
      cmd.port   = dest_port_next;
      cmd.reason = lpf_pkg::REASON_TRUNCATED;
      case (parse_phase_next)
        lpf_pkg::PH_ETH: begin
          if (length < {4'b0000, lpf_pkg::ETH_HDR_LEN}) begin
            cmd.reason = lpf_pkg::REASON_RUNT;
          end
        end
        lpf_pkg::PH_NOT_IP: cmd.reason = lpf_pkg::REASON_NOT_IPV4;
        lpf_pkg::PH_NOT_L4: cmd.reason = lpf_pkg::REASON_NOT_L4;
        lpf_pkg::PH_L4: begin
          if (length >= need_end) begin
            cmd.lookup = 1'b1;
            cmd.reason = lpf_pkg::REASON_NO_RULE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push = take && (opcode == lpf_pkg::OP_RULE || last_byte);

  always_ff @(posedge clk) begin
    if (rst || (frame_byte && last_byte)) begin
      byte_offset   <= '0;
      ether_type    <= '0;
      tag_count     <= '0;
      network_start <= lpf_pkg::ETH_HDR_LEN;
      header_words  <= '0;
      ip_protocol   <= '0;
      dest_port     <= '0;
      parse_phase   <= lpf_pkg::PH_ETH;
    end else if (frame_byte) begin
      byte_offset   <= byte_offset_next;
      ether_type    <= ether_type_next;
      tag_count     <= tag_count_next;
      network_start <= network_start_next;
      header_words  <= header_words_next;
      ip_protocol   <= ip_protocol_next;
      dest_port     <= dest_port_next;
      parse_phase   <= parse_phase_next;
    end
  end

endmodule

@@ rtl/core/lpf_queue.sv @@
// Short command queue that decouples the parser from the rule matcher.
// Depends on lpf_pkg for the entry type and depth.
module lpf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output lpf_pkg::cmd_t head
);

  lpf_pkg::cmd_t                 slots [lpf_pkg::QUEUE_DEPTH];
  logic [lpf_pkg::QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [lpf_pkg::QUEUE_AW:0]    count;
  logic                          do_pop;

  assign full      = (count == (lpf_pkg::QUEUE_AW + 1)'(lpf_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + {{(lpf_pkg::QUEUE_AW - 1){1'b0}}, 1'b1};
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + {{(lpf_pkg::QUEUE_AW - 1){1'b0}}, 1'b1};
      end
      if (push && !do_pop) begin
        count <= count + {{lpf_pkg::QUEUE_AW{1'b0}}, 1'b1};
      end else if (!push && do_pop) begin
        count <= count - {{lpf_pkg::QUEUE_AW{1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/lpf_matcher.sv @@
// Back end of the port filter: applies rule writes and looks frames up in the rule table.
// Depends on lpf_pkg; a four-stage pipeline from queue head to the result register.
module lpf_matcher #(
  parameter int RULES = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_ready,
  input  lpf_pkg::cmd_t head,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_ready,
  output logic          verdict,
  output logic [2:0]    reason,
  output logic [6:0]    matched_index,
  output logic [63:0]   drop_total,
  output logic [63:0]   pass_total
);

  localparam int G   = lpf_pkg::GROUP_SIZE;
  localparam int NG  = (RULES + G - 1) / G;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PAD = NG * G;

  // Rule table: one row of cells, each compared in place.
  logic        ent_valid [RULES];
  logic [7:0]  ent_proto [RULES];
  logic [15:0] ent_port  [RULES];
  logic        ent_drop  [RULES];

  logic          advance;
  logic          s1_valid, s2_valid, s3_valid;
  lpf_pkg::cmd_t s1, s2, s3;
  logic [PAD-1:0] s2_match, s2_dropv;
  logic [PAD-1:0] match_now;
  logic [NG-1:0]  grp_any, grp_drop, s3_any, s3_drop;
  logic [3:0]     grp_sel [NG];
  logic [3:0]     s3_sel  [NG];

  logic            found, found_drop;
  logic [GW+3:0]   found_idx;
  logic [2:0]      reason_fin;
  logic            verdict_fin, counted;
  logic [63:0]     drop_count, pass_count, drop_next, pass_next;

  assign advance = !res_valid || res_ready;
  assign pop     = advance && cmd_ready;

  for (genvar i = 0; i < RULES; i++) begin : g_rule
    always_ff @(posedge clk) begin
      if (rst) begin
        ent_valid[i] <= 1'b0;
      end else if (pop && head.is_rule && 32'(head.index) == i) begin
        ent_valid[i] <= head.valid;
      end
    end
    always_ff @(posedge clk) begin
      if (pop && head.is_rule && 32'(head.index) == i) begin
        ent_proto[i] <= head.proto;
        ent_port[i]  <= head.port;
        ent_drop[i]  <= head.drop;
      end
    end
  end

  always_comb begin
    match_now = '0;
    for (int i = 0; i < RULES; i++) begin
      match_now[i] = ent_valid[i] && (ent_proto[i] == s1.proto) && (ent_port[i] == s1.port);
    end
  end

  // First-level priority: lowest matching entry inside each group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g]  = 1'b0;
      grp_drop[g] = 1'b0;
      grp_sel[g]  = '0;
      for (int k = G - 1; k >= 0; k--) begin
        if (s2_match[g * G + k]) begin
          grp_any[g]  = 1'b1;
          grp_drop[g] = s2_dropv[g * G + k];
          grp_sel[g]  = 4'(k);
        end
      end
    end
  end

  always_comb begin
    found      = 1'b0;
    found_drop = 1'b0;
    found_idx  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (s3_any[g]) begin
        found      = 1'b1;
        found_drop = s3_drop[g];
        found_idx  = {GW'(g), s3_sel[g]};
      end
    end
  end

  always_comb begin
    reason_fin  = s3.reason;
    verdict_fin = 1'b0;
    if (s3.lookup && found) begin
      verdict_fin = found_drop;
      reason_fin  = found_drop ? lpf_pkg::REASON_RULE_DROP : lpf_pkg::REASON_RULE_PASS;
    end
    counted   = (reason_fin != lpf_pkg::REASON_RUNT);
    drop_next = drop_count + {63'd0, counted && verdict_fin};
    pass_next = pass_count + {63'd0, counted && !verdict_fin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      res_valid  <= 1'b0;
      drop_count <= '0;
      pass_count <= '0;
    end else if (advance) begin
      s1_valid  <= cmd_ready && !head.is_rule;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_valid;
      if (s3_valid) begin
        drop_count <= drop_next;
        pass_count <= pass_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= head;
      s2 <= s1;
      s3 <= s2;
      s2_match <= match_now;
      for (int i = 0; i < PAD; i++) begin
        s2_dropv[i] <= (i < RULES) ? ent_drop[i % RULES] : 1'b0;
      end
      s3_any  <= grp_any;
      s3_drop <= grp_drop;
      s3_sel  <= grp_sel;
      if (s3_valid) begin
        verdict       <= verdict_fin;
        reason        <= reason_fin;
        matched_index <= (s3.lookup && found) ? 7'(found_idx) : 7'd0;
        drop_total    <= drop_next;
        pass_total    <= pass_next;
      end
    end
  end

endmodule

@@ rtl/core/lpf_checker.sv @@
// Port-level checks for the layer-4 port filter, bound to the top level.
// Depends on lpf_pkg for reason codes.
module lpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        verdict,
  input logic [2:0]  reason,
  input logic [6:0]  matched_index,
  input logic [63:0] drop_total,
  input logic [63:0] pass_total
);

  logic        seen;
  logic [63:0] last_drop, last_pass;
  logic        res_take;

  assign res_take = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_drop <= '0;
      last_pass <= '0;
    end else if (res_take) begin
      seen      <= 1'b1;
      last_drop <= drop_total;
      last_pass <= pass_total;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(drop_total) && $stable(reason))
    else $error("result changed while stalled");

  a_drop_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (verdict == (reason == lpf_pkg::REASON_RULE_DROP)))
    else $error("verdict and reason disagree");

  a_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && matched_index != 7'd0 |->
      (reason == lpf_pkg::REASON_RULE_PASS || reason == lpf_pkg::REASON_RULE_DROP))
    else $error("matched index without a rule match");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res_take && seen |->
      ((reason == lpf_pkg::REASON_RUNT) ?
         (drop_total == last_drop && pass_total == last_pass) :
         (verdict ? (drop_total == last_drop + 64'd1 && pass_total == last_pass)
                  : (pass_total == last_pass + 64'd1 && drop_total == last_drop))))
    else $error("counters moved wrongly");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind l4_port_firewall_filter lpf_checker u_lpf_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .verdict      (result.verdict),
  .reason       (result.reason),
  .matched_index(result.matched_index),
  .drop_total   (result.drop_total),
  .pass_total   (result.pass_total)
);

@@ tb/sv/l4_port_firewall_filter_tb.sv @@
// Testbench for l4_port_firewall_filter: directed frames and rule writes, then random traffic,
// each verdict checked against an in-bench parser and rule matcher.
// Depends on lpf_pkg, lpf_in_if, lpf_out_if and the filter RTL.
`timescale 1ns / 1ps

module l4_port_firewall_filter_tb;

  typedef struct {
    logic        opcode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [6:0]  rule_index;
    logic [7:0]  rule_protocol;
    logic [15:0] rule_port;
    logic [7:0]  rule_action;
    logic        rule_valid;
  } item_t;

  typedef struct {
    logic        verdict;
    logic [2:0]  reason;
    logic [6:0]  matched_index;
    logic [63:0] drop_total;
    logic [63:0] pass_total;
  } verdict_t;

  typedef struct {
    logic        is_rule;
    logic [6:0]  idx;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [7:0]  action;
    logic        valid;
    int          ntags;
    logic [15:0] etype;
    int          ihl;
    int          len;
    int          want;
  } row_t;

  typedef struct {
    logic [7:0]  proto;
    logic [15:0] port;
    logic [7:0]  action;
    logic        valid;
  } rule_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpf_in_if  item();
  lpf_out_if result();

  l4_port_firewall_filter dut (.clk(clk), .rst(rst), .item(item), .result(result));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the filter's parse state, rule table and counters.
  logic [7:0]      sh_offset;
  logic [15:0]     sh_type;
  int              sh_tags;
  int              sh_net_start;
  int              sh_words;
  logic [7:0]      sh_proto;
  logic [15:0]     sh_port;
  lpf_pkg::phase_t sh_phase;
  rule_t           sh_rules [128];
  logic [63:0]     sh_drops;
  logic [63:0]     sh_passes;

  verdict_t verdicts_due[$];
  int       errors = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       idle_cycles = 0;
  int       items_sent = 0;
  int       frames_sent = 0;

  function automatic void clear_frame_state();
    sh_offset = '0;
    sh_type = '0;
    sh_tags = 0;
    sh_net_start = 14;
    sh_words = 0;
    sh_proto = '0;
    sh_port = '0;
    sh_phase = lpf_pkg::PH_ETH;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    int pos;
    int rel;
    pos = sh_offset;
    if (sh_phase == lpf_pkg::PH_ETH) begin
      if (pos == sh_net_start - 2) begin
        sh_type[15:8] = b;
      end else if (pos == sh_net_start - 1) begin
        sh_type[7:0] = b;
        if ((sh_type == lpf_pkg::TYPE_VLAN || sh_type == lpf_pkg::TYPE_QINQ) && sh_tags < 2)
        begin
          sh_tags++;
          sh_net_start += 4;
        end else if (sh_type == lpf_pkg::TYPE_IPV4) begin
          sh_phase = lpf_pkg::PH_IP;
        end else begin
          sh_phase = lpf_pkg::PH_NOT_IP;
        end
      end
    end else if (sh_phase == lpf_pkg::PH_IP) begin
      rel = pos - sh_net_start;
      if (rel == 0) sh_words = int'(b[3:0]);
      else if (rel == 9) sh_proto = b;
      if (rel == 19 && sh_words < 5) begin
        sh_phase = lpf_pkg::PH_BAD;
      end else if (rel >= 19 && rel == sh_words * 4 - 1) begin
        sh_phase = (sh_proto == lpf_pkg::PROTO_TCP || sh_proto == lpf_pkg::PROTO_UDP) ?
                   lpf_pkg::PH_L4 : lpf_pkg::PH_NOT_L4;
      end
    end else if (sh_phase == lpf_pkg::PH_L4) begin
      rel = pos - sh_net_start - sh_words * 4;
      if (rel == 2) sh_port[15:8] = b;
      else if (rel == 3) sh_port[7:0] = b;
    end
    if (sh_offset != 8'd255) sh_offset++;
  endfunction

  // Applies one accepted transaction; returns the reason of a finished frame, or -1.
  function automatic int filter_item(item_t it);
    verdict_t v;
    int len;
    int need;
    if (it.opcode == lpf_pkg::OP_RULE) begin
      sh_rules[it.rule_index] = '{it.rule_protocol, it.rule_port, it.rule_action, it.rule_valid};
      return -1;
    end
    len = sh_offset + 1;
    parse_byte(it.data_byte);
    if (!it.last_byte) return -1;
    v.verdict = 1'b0;
    v.reason = lpf_pkg::REASON_TRUNCATED;
    v.matched_index = '0;
    if (sh_phase == lpf_pkg::PH_ETH && len < 14) v.reason = lpf_pkg::REASON_RUNT;
    else if (sh_phase == lpf_pkg::PH_NOT_IP) v.reason = lpf_pkg::REASON_NOT_IPV4;
    else if (sh_phase == lpf_pkg::PH_NOT_L4) v.reason = lpf_pkg::REASON_NOT_L4;
    else if (sh_phase == lpf_pkg::PH_L4) begin
      need = (sh_proto == lpf_pkg::PROTO_UDP) ? 8 : 20;
      if (len >= sh_net_start + sh_words * 4 + need) begin
        v.reason = lpf_pkg::REASON_NO_RULE;
        for (int i = 0; i < 128; i++) begin
          if (sh_rules[i].valid && sh_rules[i].proto == sh_proto &&
              sh_rules[i].port == sh_port) begin
            v.matched_index = i[6:0];
            v.verdict = (sh_rules[i].action == lpf_pkg::ACTION_DROP);
            v.reason = v.verdict ? lpf_pkg::REASON_RULE_DROP : lpf_pkg::REASON_RULE_PASS;
            break;
          end
        end
      end
    end
    if (v.reason != lpf_pkg::REASON_RUNT) begin
      if (v.verdict) sh_drops++;
      else sh_passes++;
    end
    v.drop_total = sh_drops;
    v.pass_total = sh_passes;
    verdicts_due.push_back(v);
    clear_frame_state();
    return int'(v.reason);
  endfunction

  task automatic send_item(input item_t it, output int reason);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.opcode <= it.opcode;
    item.data_byte <= it.data_byte;
    item.last_byte <= it.last_byte;
    item.rule_index <= it.rule_index;
    item.rule_protocol <= it.rule_protocol;
    item.rule_port <= it.rule_port;
    item.rule_action <= it.rule_action;
    item.rule_valid <= it.rule_valid;
    item.valid <= 1'b1;
    do @(posedge clk); while (!item.ready);
    reason = filter_item(it);
    items_sent++;
  endtask

  task automatic send_rule(input logic [6:0] idx, input logic [7:0] proto,
                           input logic [15:0] port, input logic [7:0] action,
                           input logic valid);
    item_t it;
    int r;
    it.opcode = lpf_pkg::OP_RULE;
    it.data_byte = 8'($urandom_range(255));
    it.last_byte = 1'($urandom_range(1));
    it.rule_index = idx;
    it.rule_protocol = proto;
    it.rule_port = port;
    it.rule_action = action;
    it.rule_valid = valid;
    send_item(it, r);
  endtask

  // Builds and sends one frame; len 0 means the whole frame with a short payload.
  task automatic send_frame(input int ntags, input logic [15:0] etype, input int ihl,
                            input logic [7:0] proto, input logic [15:0] port,
                            input int len, output int reason);
    logic [7:0] bytes[$];
    item_t it;
    int hdr;
    int r;
    repeat (12) bytes.push_back(8'($urandom_range(255)));
    for (int t = 0; t < ntags; t++) begin
      logic [15:0] tpid;
      tpid = $urandom_range(1) ? lpf_pkg::TYPE_VLAN : lpf_pkg::TYPE_QINQ;
      bytes.push_back(tpid[15:8]);
      bytes.push_back(tpid[7:0]);
      repeat (2) bytes.push_back(8'($urandom_range(255)));
    end
    bytes.push_back(etype[15:8]);
    bytes.push_back(etype[7:0]);
    hdr = (ihl < 5) ? 20 : ihl * 4;
    for (int i = 0; i < hdr; i++) begin
      if (i == 0) bytes.push_back({4'h4, ihl[3:0]});
      else if (i == 9) bytes.push_back(proto);
      else bytes.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < 20; i++) begin
      if (i == 2) bytes.push_back(port[15:8]);
      else if (i == 3) bytes.push_back(port[7:0]);
      else bytes.push_back(8'($urandom_range(255)));
    end
    repeat ($urandom_range(6)) bytes.push_back(8'($urandom_range(255)));
    if (len == 0) len = bytes.size();
    while (bytes.size() < len) bytes.push_back(8'($urandom_range(255)));
    reason = -1;
    for (int i = 0; i < len; i++) begin
      it.opcode = lpf_pkg::OP_FRAME;
      it.data_byte = bytes[i];
      it.last_byte = (i == len - 1);
      it.rule_index = 7'($urandom_range(127));
      it.rule_protocol = 8'($urandom_range(255));
      it.rule_port = 16'($urandom_range(65535));
      it.rule_action = 8'($urandom_range(255));
      it.rule_valid = 1'($urandom_range(1));
      send_item(it, r);
      if (r >= 0) reason = r;
    end
    frames_sent++;
  endtask

  function automatic row_t rule_row(logic [6:0] idx, logic [7:0] proto, logic [15:0] port,
                                    logic [7:0] action, logic valid);
    row_t r;
    r = '{1'b1, idx, proto, port, action, valid, 0, 16'h0, 0, 0, -1};
    return r;
  endfunction

  function automatic row_t frame_row(int ntags, logic [15:0] etype, int ihl,
                                     logic [7:0] proto, logic [15:0] port, int len, int want);
    row_t r;
    r = '{1'b0, 7'd0, proto, port, 8'd0, 1'b0, ntags, etype, ihl, len, want};
    return r;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(5))
      0: return 16'd80;
      1: return 16'd443;
      2: return 16'd53;
      3: return 16'hFFFF;
      4: return 16'd0;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(4))
      0, 1: return lpf_pkg::PROTO_TCP;
      2, 3: return lpf_pkg::PROTO_UDP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Receiver: ready changes only at the falling edge.
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && result.valid && result.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict with no frame pending: reason %0d", result.reason);
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        if (result.verdict !== v.verdict) begin
          $error("verdict: expected %0d, got %0d", v.verdict, result.verdict);
          errors++;
        end
        if (result.reason !== v.reason) begin
          $error("reason: expected %0d, got %0d", v.reason, result.reason);
          errors++;
        end
        if (result.matched_index !== v.matched_index) begin
          $error("matched_index: expected %0d, got %0d", v.matched_index, result.matched_index);
          errors++;
        end
        if (result.drop_total !== v.drop_total) begin
          $error("drop_total: expected %0d, got %0d", v.drop_total, result.drop_total);
          errors++;
        end
        if (result.pass_total !== v.pass_total) begin
          $error("pass_total: expected %0d, got %0d", v.pass_total, result.pass_total);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("l4_port_firewall_filter_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    int reason;
    int drain;
    item.valid = 1'b0;
    item.opcode = lpf_pkg::OP_FRAME;
    item.data_byte = '0;
    item.last_byte = 1'b0;
    item.rule_index = '0;
    item.rule_protocol = '0;
    item.rule_port = '0;
    item.rule_action = '0;
    item.rule_valid = 1'b0;
    for (int i = 0; i < 128; i++) sh_rules[i] = '{8'd0, 16'd0, 8'd0, 1'b0};
    sh_drops = '0;
    sh_passes = '0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 0,
                             lpf_pkg::REASON_NO_RULE));
    rows.push_back(rule_row(7'd0, lpf_pkg::PROTO_TCP, 16'd80, lpf_pkg::ACTION_DROP, 1'b1));
    rows.push_back(rule_row(7'd127, lpf_pkg::PROTO_UDP, 16'd53, 8'd0, 1'b1));
    rows.push_back(rule_row(7'd5, lpf_pkg::PROTO_TCP, 16'd80, 8'd0, 1'b1));
    rows.push_back(rule_row(7'd1, lpf_pkg::PROTO_TCP, 16'hFFFF, 8'hFF, 1'b1));
    rows.push_back(rule_row(7'd2, 8'hFF, 16'd0, lpf_pkg::ACTION_DROP, 1'b1));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 1,
                             lpf_pkg::REASON_RUNT));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 13,
                             lpf_pkg::REASON_RUNT));
    rows.push_back(frame_row(0, 16'h86DD, 5, lpf_pkg::PROTO_TCP, 16'd80, 14,
                             lpf_pkg::REASON_NOT_IPV4));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 0,
                             lpf_pkg::REASON_RULE_DROP));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_UDP, 16'd53, 0,
                             lpf_pkg::REASON_RULE_PASS));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd443, 0,
                             lpf_pkg::REASON_NO_RULE));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, 8'd1, 16'd80, 0,
                             lpf_pkg::REASON_NOT_L4));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 3, lpf_pkg::PROTO_TCP, 16'd80, 0,
                             lpf_pkg::REASON_TRUNCATED));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 40,
                             lpf_pkg::REASON_TRUNCATED));
    rows.push_back(frame_row(2, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 0,
                             lpf_pkg::REASON_RULE_DROP));
    rows.push_back(frame_row(3, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 0,
                             lpf_pkg::REASON_NOT_IPV4));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 15, lpf_pkg::PROTO_UDP, 16'd53, 0, -1));
    rows.push_back(frame_row(1, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'hFFFF, 0,
                             lpf_pkg::REASON_RULE_PASS));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, 8'hFF, 16'd0, 0,
                             lpf_pkg::REASON_NOT_L4));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_UDP, 16'd80, 300, -1));
    rows.push_back(rule_row(7'd0, lpf_pkg::PROTO_TCP, 16'd80, lpf_pkg::ACTION_DROP, 1'b0));
    rows.push_back(frame_row(0, lpf_pkg::TYPE_IPV4, 5, lpf_pkg::PROTO_TCP, 16'd80, 0,
                             lpf_pkg::REASON_RULE_PASS));

    foreach (rows[i]) begin
      if (rows[i].is_rule) begin
        send_rule(rows[i].idx, rows[i].proto, rows[i].port, rows[i].action, rows[i].valid);
      end else begin
        send_frame(rows[i].ntags, rows[i].etype, rows[i].ihl, rows[i].proto, rows[i].port,
                   rows[i].len, reason);
        if (rows[i].want >= 0 && reason != rows[i].want) begin
          $error("reason of directed frame %0d: expected %0d, got %0d", i, rows[i].want,
                 reason);
          errors++;
        end
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 63; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 63; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      while (items_sent < 1150 + 160 * (phase + 1) || frames_sent < 17 + 2 * (phase + 1))
      begin
        case ($urandom_range(9))
          0: send_rule($urandom_range(1) ? 7'($urandom_range(15)) : 7'($urandom_range(127)),
                       pick_proto(), pick_port(),
                       $urandom_range(1) ? lpf_pkg::ACTION_DROP : 8'($urandom_range(255)),
                       $urandom_range(3) != 0);
          1: send_frame($urandom_range(3),
                        $urandom_range(1) ? lpf_pkg::TYPE_IPV4 : 16'($urandom_range(65535)),
                        $urandom_range(15), 8'($urandom_range(255)),
                        16'($urandom_range(65535)), $urandom_range(1, 80), reason);
          2: send_frame($urandom_range(2), lpf_pkg::TYPE_IPV4, $urandom_range(5, 7),
                        pick_proto(), pick_port(), $urandom_range(14, 60), reason);
          default: send_frame($urandom_range(2), lpf_pkg::TYPE_IPV4,
                              $urandom_range(3) ? 5 : $urandom_range(15), pick_proto(),
                              pick_port(), 0, reason);
        endcase
      end
      if (phase == 1) begin
        // Hold the input off until every pending verdict has been delivered.
        @(negedge clk);
        item.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    item.valid <= 1'b0;
    drain = 0;
    while (verdicts_due.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("l4_port_firewall_filter_tb: clean");
    end else begin
      if (verdicts_due.size() != 0) $error("%0d verdicts never arrived", verdicts_due.size());
      $display("l4_port_firewall_filter_tb: errors");
    end
    $finish;
  end

endmodule
